// ----- rtl/gzhp_pkg.sv -----
`default_nettype none

package gzhp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned SKIP_W  = 16;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_ENCRYPTED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_MULTIPART   = 3'd2;
    localparam logic [STAT_W-1:0] ST_RESV_FLAGS  = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNSUPPORTED = 3'd4;
    localparam logic [STAT_W-1:0] ST_CORRUPT_1ST = 3'd5;
    localparam logic [STAT_W-1:0] ST_CORRUPT_NTH = 3'd6;

    // Header flag bits
    localparam logic [BYTE_W-1:0] FL_MULTI   = 8'h02;
    localparam logic [BYTE_W-1:0] FL_EXTRA   = 8'h04;
    localparam logic [BYTE_W-1:0] FL_NAME    = 8'h08;
    localparam logic [BYTE_W-1:0] FL_COMMENT = 8'h10;
    localparam logic [BYTE_W-1:0] FL_CRYPT   = 8'h20;
    localparam logic [BYTE_W-1:0] FL_RESV    = 8'hC0;

    // Magic bytes
    localparam logic [BYTE_W-1:0] MG_GZ0     = 8'h1F;
    localparam logic [BYTE_W-1:0] MG_GZ1     = 8'h8B;
    localparam logic [BYTE_W-1:0] MG_GZ1_OLD = 8'h9E;
    localparam logic [BYTE_W-1:0] MG_PACK1   = 8'h1E;
    localparam logic [BYTE_W-1:0] MG_LZW1    = 8'h9D;
    localparam logic [BYTE_W-1:0] MG_PK0     = 8'h50;
    localparam logic [BYTE_W-1:0] MG_PK1     = 8'h4B;

    localparam logic [SKIP_W-1:0] FIXED_LEN  = 16'd6;
    localparam logic [SKIP_W-1:0] PART_LEN   = 16'd2;

    typedef enum logic [10:0] {
        PH_IDLE    = 11'b000_0000_0001,
        PH_MAGIC2  = 11'b000_0000_0010,
        PH_METHOD  = 11'b000_0000_0100,
        PH_FLAGS   = 11'b000_0000_1000,
        PH_FIXED   = 11'b000_0001_0000,
        PH_PART    = 11'b000_0010_0000,
        PH_XLO     = 11'b000_0100_0000,
        PH_XHI     = 11'b000_1000_0000,
        PH_XDATA   = 11'b001_0000_0000,
        PH_NAME    = 11'b010_0000_0000,
        PH_COMMENT = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [BYTE_W-1:0]   first_magic;
        logic [BYTE_W-1:0]   method_seen;
        logic [BYTE_W-1:0]   flag_bits;
        logic [SKIP_W-1:0]   skip_count;
        logic [BYTE_W-1:0]   members_started;
    } t_state;

    typedef struct packed {
        logic                valid;
        logic [STAT_W-1:0]   status;
        logic [BYTE_W-1:0]   method;
        logic [BYTE_W-1:0]   member_number;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/gzhp_if.sv -----
`default_nettype none

interface gzhp_in_if;
    logic                         valid;
    logic                         ready;
    logic [gzhp_pkg::BYTE_W-1:0]  data_byte;
    logic                         member_start;

    modport source (output valid, output data_byte, output member_start, input ready);
    modport sink   (input valid, input data_byte, input member_start, output ready);
endinterface

interface gzhp_out_if;
    logic                         valid;
    logic                         ready;
    logic [gzhp_pkg::STAT_W-1:0]  status;
    logic [gzhp_pkg::BYTE_W-1:0]  method;
    logic [gzhp_pkg::BYTE_W-1:0]  member_number;

    modport source (output valid, output status, output method, output member_number,
                    input ready);
    modport sink   (input valid, input status, input method, input member_number,
                    output ready);
endinterface

interface gzhp_cfg_if;
    logic valid;
    logic ready;
    logic allow_flag_errors;

    modport source (output valid, output allow_flag_errors, input ready);
    modport sink   (input valid, input allow_flag_errors, output ready);
endinterface

`default_nettype wire

// ----- rtl/gzip_member_header_parser.sv -----
// gzip member header parser.
// i_in carries one stream byte per beat plus member_start, which marks the
// first magic byte of a new member and restarts the parser. o_out carries
// at most one result per header: status, method byte and member count.
// i_cfg writes allow_flag_errors; it is always ready and should be written
// only while the parser is idle.
// Throughput: one input beat per cycle. The header state machine advances
// in the same cycle the byte is accepted; a result lands in the output
// register and is visible in the cycle after the byte that finished the header.
// The single output register sets the rate: a new byte is accepted while
// the register is empty or being drained in the same cycle.
// When the receiver stalls with a result pending, input ready drops until
// the result is taken; bytes that give no result are never lost.
// Reset (synchronous, active low) returns the parser to idle, clears the
// member count and the flag register, and empties the output register.
`default_nettype none

module gzip_member_header_parser (
    input  var logic    i_clk,
    input  var logic    i_rst_n,
    gzhp_in_if.sink     i_in,
    gzhp_cfg_if.sink    i_cfg,
    gzhp_out_if.source  o_out
);
    import gzhp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result step_res;
    logic    r_allow;
    logic    r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [BYTE_W-1:0] r_method;
    logic [BYTE_W-1:0] r_member;
    logic    in_beat;
    logic    out_beat;

    assign out_beat   = r_out_valid && o_out.ready;
    // Take a byte while the result slot is free or draining this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_beat    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    gzhp_step u_step (
        .i_state  (r_state),
        .i_byte   (i_in.data_byte),
        .i_start  (i_in.member_start),
        .i_allow  (r_allow),
        .o_state  (n_state),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow <= 1'b0;
        end else if (i_cfg.valid) begin
            r_allow <= i_cfg.allow_flag_errors;
        end
    end

    // Header state: advance on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= PH_IDLE;
            r_state.first_magic     <= '0;
            r_state.method_seen     <= '0;
            r_state.flag_bits       <= '0;
            r_state.skip_count      <= '0;
            r_state.members_started <= '0;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    // Result register: load on a beat that finishes a header, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat && step_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && step_res.valid) begin
            r_status <= step_res.status;
            r_method <= step_res.method;
            r_member <= step_res.member_number;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.method        = r_method;
    assign o_out.member_number = r_member;

    // A pending result that is not taken must block input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !i_in.ready)
        else $error("input accepted while result stalled");

    // A member start always puts the parser on the second magic byte
    a_start_magic2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_in.member_start |=> r_state.phase == PH_MAGIC2)
        else $error("member start did not restart header");

    // Member count never goes backward
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> r_state.members_started >= $past(r_state.members_started))
        else $error("member count decreased");

    // A result never comes from a member start beat
    a_no_res_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_in.member_start |-> !step_res.valid)
        else $error("result on member start");

    // Status codes stay in range
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_status <= ST_CORRUPT_NTH)
        else $error("status out of range");

endmodule

`default_nettype wire

// ----- rtl/gzhp_step.sv -----
`default_nettype none

module gzhp_step (
    input  var gzhp_pkg::t_state                 i_state,
    input  var logic [gzhp_pkg::BYTE_W-1:0]      i_byte,
    input  var logic                             i_start,
    input  var logic                             i_allow,
    output gzhp_pkg::t_state                     o_state,
    output gzhp_pkg::t_result                    o_result
);
    import gzhp_pkg::*;

    // Section order used to find the next optional field
    localparam logic [3:0] RK_FIXED   = 4'd4;
    localparam logic [3:0] RK_PART    = 4'd5;
    localparam logic [3:0] RK_XLO     = 4'd6;
    localparam logic [3:0] RK_XHI     = 4'd7;
    localparam logic [3:0] RK_XDATA   = 4'd8;
    localparam logic [3:0] RK_NAME    = 4'd9;
    localparam logic [3:0] RK_COMMENT = 4'd10;

    logic [3:0]         done_rank;
    t_phase             adv_phase;
    logic               adv_emit;
    logic [STAT_W-1:0]  adv_status;
    logic [SKIP_W-1:0]  xlen;
    logic               gz_magic;
    logic               other_fmt;

    always_comb begin
        case (i_state.phase)
            PH_FIXED: done_rank = RK_FIXED;
            PH_PART:  done_rank = RK_PART;
            PH_XHI:   done_rank = RK_XHI;
            PH_XDATA: done_rank = RK_XDATA;
            PH_NAME:  done_rank = RK_NAME;
            default:  done_rank = RK_COMMENT;
        endcase
    end

    // Pick the next optional section after the one just finished, or finish
    always_comb begin
        adv_phase  = PH_IDLE;
        adv_emit   = 1'b0;
        adv_status = ST_OK;
        if (done_rank < RK_PART && (i_state.flag_bits & FL_MULTI) != '0) begin
            adv_phase = PH_PART;
        end else if (done_rank < RK_XLO && (i_state.flag_bits & FL_EXTRA) != '0) begin
            adv_phase = PH_XLO;
        end else if (done_rank < RK_NAME && (i_state.flag_bits & FL_NAME) != '0) begin
            adv_phase = PH_NAME;
        end else if (done_rank < RK_COMMENT && (i_state.flag_bits & FL_COMMENT) != '0) begin
            adv_phase = PH_COMMENT;
        end else begin
            adv_emit = 1'b1;
            if ((i_state.flag_bits & FL_MULTI) != '0) begin
                adv_status = ST_MULTIPART;
            end else if ((i_state.flag_bits & FL_RESV) != '0) begin
                adv_status = ST_RESV_FLAGS;
            end
        end
    end

    assign xlen      = i_state.skip_count | {i_byte, 8'h00};
    assign gz_magic  = (i_state.first_magic == MG_GZ0)
                    && (i_byte == MG_GZ1 || i_byte == MG_GZ1_OLD);
    assign other_fmt = ((i_state.first_magic == MG_GZ0)
                        && (i_byte == MG_PACK1 || i_byte == MG_LZW1))
                    || ((i_state.first_magic == MG_PK0) && (i_byte == MG_PK1));

    always_comb begin
        o_state                = i_state;
        o_result.valid         = 1'b0;
        o_result.status        = ST_OK;
        o_result.method        = '0;
        o_result.member_number = i_state.members_started;

        if (i_start) begin
            if (i_state.members_started != '1) begin
                o_state.members_started = i_state.members_started + 8'd1;
            end
            o_state.first_magic = i_byte;
            o_state.method_seen = '0;
            o_state.flag_bits   = '0;
            o_state.skip_count  = '0;
            o_state.phase       = PH_MAGIC2;
        end else begin
            case (i_state.phase)
                PH_MAGIC2: begin
                    if (gz_magic) begin
                        o_state.phase = PH_METHOD;
                    end else begin
                        o_state.phase  = PH_IDLE;
                        o_result.valid = 1'b1;
                        if (other_fmt) begin
                            o_result.status = ST_UNSUPPORTED;
                        end else if (i_state.members_started == 8'd1) begin
                            o_result.status = ST_CORRUPT_1ST;
                        end else begin
                            o_result.status = ST_CORRUPT_NTH;
                        end
                    end
                end
                PH_METHOD: begin
                    o_state.method_seen = i_byte;
                    o_state.phase       = PH_FLAGS;
                end
                PH_FLAGS: begin
                    o_state.flag_bits = i_byte;
                    o_result.method   = i_state.method_seen;
                    if ((i_byte & FL_CRYPT) != '0) begin
                        o_state.phase   = PH_IDLE;
                        o_result.valid  = 1'b1;
                        o_result.status = ST_ENCRYPTED;
                    end else if ((i_byte & FL_MULTI) != '0 && !i_allow) begin
                        o_state.phase   = PH_IDLE;
                        o_result.valid  = 1'b1;
                        o_result.status = ST_MULTIPART;
                    end else if ((i_byte & FL_RESV) != '0 && !i_allow) begin
                        o_state.phase   = PH_IDLE;
                        o_result.valid  = 1'b1;
                        o_result.status = ST_RESV_FLAGS;
                    end else begin
                        o_state.phase      = PH_FIXED;
                        o_state.skip_count = FIXED_LEN;
                    end
                end
                PH_FIXED, PH_PART, PH_XDATA: begin
                    if (i_state.skip_count <= 16'd1) begin
                        o_state.skip_count = (adv_phase == PH_PART) ? PART_LEN : '0;
                        o_state.phase      = adv_phase;
                        o_result.valid     = adv_emit;
                        o_result.status    = adv_status;
                        o_result.method    = i_state.method_seen;
                    end else begin
                        o_state.skip_count = i_state.skip_count - 16'd1;
                    end
                end
                PH_XLO: begin
                    o_state.skip_count = {8'h00, i_byte};
                    o_state.phase      = PH_XHI;
                end
                PH_XHI: begin
                    o_state.skip_count = xlen;
                    if (xlen == '0) begin
                        o_state.phase   = adv_phase;
                        o_result.valid  = adv_emit;
                        o_result.status = adv_status;
                        o_result.method = i_state.method_seen;
                    end else begin
                        o_state.phase = PH_XDATA;
                    end
                end
                PH_NAME, PH_COMMENT: begin
                    if (i_byte == '0) begin
                        o_state.phase   = adv_phase;
                        o_result.valid  = adv_emit;
                        o_result.status = adv_status;
                        o_result.method = i_state.method_seen;
                    end
                end
                default: begin
                    o_state.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
